### sv/bmftl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bmftl_pkg;

  // geometry
  localparam int PAGES_PER_BLK = 4;
  localparam int NUM_BLOCKS    = 16;
  localparam int DATA_BLOCKS   = NUM_BLOCKS - 1;
  localparam int OFF_W         = $clog2(PAGES_PER_BLK);
  localparam int PBN_W         = $clog2(NUM_BLOCKS);
  localparam int MAP_IDX_W     = $clog2(DATA_BLOCKS);

  // field widths
  localparam int LSN_W  = 6;
  localparam int LBN_W  = LSN_W - OFF_W;
  localparam int SLOT_W = 4;
  localparam int CMD_W  = 3;
  localparam int ADDR_W = 6;

  // flash command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_READ  = 3'd0,
    CMD_PROG  = 3'd1,
    CMD_MARK  = 3'd2,
    CMD_COPY  = 3'd3,
    CMD_ERASE = 3'd4
  } cmd_e_t;

  // request opcode
  localparam logic OP_WRITE = 1'b1;

  // kind of command the datapath should build this cycle
  typedef enum logic [2:0] {
    EM_NONE,
    EM_READ,
    EM_PROG_FIRST,
    EM_PROG_INPLACE,
    EM_MARK,
    EM_COPY,
    EM_PROG_NEW,
    EM_ERASE
  } emit_e_t;

  typedef struct packed {
    logic    capture;
    emit_e_t emit;
    logic    cnt_clr;
    logic    cnt_inc;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_write;
    logic inrange;
    logic mapped;
    logic written;
    logic off_zero;
    logic cnt_is_off;
    logic cnt_last;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

### sv/block_mapped_ftl.sv
`timescale 1ns / 1ps
`default_nettype none

// Block-mapped flash translation controller. Each request transaction (op, lsn,
// buffer_slot) turns into one or more flash command transactions, the final one
// flagged by last; a write past the data blocks produces none. One request is
// handled at a time, paced by the sequencer: a read or an in-place program passes
// through a decision and one command, a first write at a nonzero offset issues a
// program plus a marker, and an overwrite steps through a decision, one pass per
// page of the block for the copies, a new-data program and an erase. Output back
// pressure stalls the sequencer in the state that is waiting to emit. A result sits in
// an output register, so the next request is taken while the final command of the
// previous one is still waiting. Map and page bitmaps live in flip-flops cleared
// by reset, so the block is ready right after reset with no clearing pass.

module block_mapped_ftl
  import bmftl_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              op,
  input  logic [LSN_W-1:0]  lsn,
  input  logic [SLOT_W-1:0] buffer_slot,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CMD_W-1:0]  command,
  output logic [ADDR_W-1:0] page_addr,
  output logic [ADDR_W-1:0] src_page,
  output logic [PBN_W-1:0]  erase_block,
  output logic [SLOT_W-1:0] slot_out,
  output logic              unmapped,
  output logic              last
);

  // command and status between sequencer and datapath
  ctrl_cmd_t  cmd;
  dp_status_t status;

  // sequencer: picks the command sequence for each request
  bmftl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath: request registers, map, bitmaps, free block, output register
  bmftl_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .op          (op),
    .lsn         (lsn),
    .buffer_slot (buffer_slot),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .command     (command),
    .page_addr   (page_addr),
    .src_page    (src_page),
    .erase_block (erase_block),
    .slot_out    (slot_out),
    .unmapped    (unmapped),
    .last        (last)
  );

endmodule

`default_nettype wire

### sv/bmftl_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module bmftl_ctrl
  import bmftl_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DECIDE = 6'b000010,
    S_MARK   = 6'b000100,
    S_COPY   = 6'b001000,
    S_PROG   = 6'b010000,
    S_ERASE  = 6'b100000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.emit    = EM_NONE;
    cmd.cnt_clr = 1'b0;
    cmd.cnt_inc = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (!status.is_write) begin
          if (status.out_free) begin
            cmd.emit   = EM_READ;
            state_next = S_IDLE;
          end
        end else if (!status.inrange) begin
          // write past the data blocks is dropped
          state_next = S_IDLE;
        end else if (!status.mapped) begin
          if (status.out_free) begin
            cmd.emit   = EM_PROG_FIRST;
            state_next = status.off_zero ? S_IDLE : S_MARK;
          end
        end else if (!status.written) begin
          if (status.out_free) begin
            cmd.emit   = EM_PROG_INPLACE;
            state_next = S_IDLE;
          end
        end else begin
          cmd.cnt_clr = 1'b1;
          state_next  = S_COPY;
        end
      end
      S_MARK: begin
        if (status.out_free) begin
          cmd.emit   = EM_MARK;
          state_next = S_IDLE;
        end
      end
      S_COPY: begin
        if (status.cnt_is_off) begin
          cmd.cnt_inc = 1'b1;
          if (status.cnt_last) state_next = S_PROG;
        end else if (status.out_free) begin
          cmd.emit    = EM_COPY;
          cmd.cnt_inc = 1'b1;
          if (status.cnt_last) state_next = S_PROG;
        end
      end
      S_PROG: begin
        if (status.out_free) begin
          cmd.emit   = EM_PROG_NEW;
          state_next = S_ERASE;
        end
      end
      S_ERASE: begin
        if (status.out_free) begin
          cmd.emit   = EM_ERASE;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### sv/bmftl_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module bmftl_dp
  import bmftl_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  ctrl_cmd_t         cmd,
  output dp_status_t        status,
  input  logic              op,
  input  logic [LSN_W-1:0]  lsn,
  input  logic [SLOT_W-1:0] buffer_slot,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CMD_W-1:0]  command,
  output logic [ADDR_W-1:0] page_addr,
  output logic [ADDR_W-1:0] src_page,
  output logic [PBN_W-1:0]  erase_block,
  output logic [SLOT_W-1:0] slot_out,
  output logic              unmapped,
  output logic              last
);

  // request registers
  logic              op_q;
  logic [LSN_W-1:0]  lsn_q;
  logic [SLOT_W-1:0] slot_q;
  logic [OFF_W-1:0]  cnt;

  // translation state
  logic                     map_valid [DATA_BLOCKS];
  logic [PBN_W-1:0]         map_pbn   [DATA_BLOCKS];
  logic [PAGES_PER_BLK-1:0] pw        [NUM_BLOCKS];
  logic [PBN_W-1:0]         free_blk;

  logic [LBN_W-1:0]         lbn;
  logic [OFF_W-1:0]         off;
  logic                     inrange;
  logic [MAP_IDX_W-1:0]     midx;
  logic                     mapped;
  logic [PBN_W-1:0]         pbn;
  logic [PAGES_PER_BLK-1:0] bitmask;
  logic                     out_free;

  // fields of the command being built
  logic [CMD_W-1:0]  command_next;
  logic [ADDR_W-1:0] page_addr_next;
  logic [ADDR_W-1:0] src_page_next;
  logic [PBN_W-1:0]  erase_block_next;
  logic [SLOT_W-1:0] slot_out_next;
  logic              unmapped_next;
  logic              last_next;

  assign lbn     = lsn_q[LSN_W-1:OFF_W];
  assign off     = lsn_q[OFF_W-1:0];
  assign inrange = lbn < LBN_W'(DATA_BLOCKS);
  assign midx    = inrange ? MAP_IDX_W'(lbn) : '0;
  assign mapped  = inrange && map_valid[midx];
  assign pbn     = map_pbn[midx];
  assign bitmask = PAGES_PER_BLK'(1) << off;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    status.is_write   = (op_q == OP_WRITE);
    status.inrange    = inrange;
    status.mapped     = mapped;
    status.written    = |(pw[pbn] & bitmask);
    status.off_zero   = (off == '0);
    status.cnt_is_off = (cnt == off);
    status.cnt_last   = (cnt == OFF_W'(PAGES_PER_BLK - 1));
    status.out_free   = out_free;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q   <= op;
      lsn_q  <= lsn;
      slot_q <= buffer_slot;
    end
    if (cmd.cnt_clr) begin
      cnt <= '0;
    end else if (cmd.cnt_inc) begin
      cnt <= cnt + OFF_W'(1);
    end
  end

  // map, bitmaps and free block
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int b = 0; b < DATA_BLOCKS; b++) begin
        map_valid[b] <= 1'b0;
      end
      for (int b = 0; b < NUM_BLOCKS; b++) begin
        pw[b] <= '0;
      end
      free_blk <= PBN_W'(NUM_BLOCKS - 1);
    end else begin
      case (cmd.emit)
        EM_PROG_FIRST: begin
          map_valid[midx]    <= 1'b1;
          map_pbn[midx]      <= PBN_W'(lbn);
          pw[PBN_W'(lbn)]    <= pw[PBN_W'(lbn)] | bitmask;
        end
        EM_PROG_INPLACE: begin
          pw[pbn] <= pw[pbn] | bitmask;
        end
        EM_ERASE: begin
          // an old block that is also the free block keeps the merged bits
          if (pbn != free_blk) begin
            pw[pbn] <= '0;
          end
          pw[free_blk]  <= pw[pbn] | bitmask;
          map_pbn[midx] <= free_blk;
          free_blk      <= pbn;
        end
        default: begin
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit != EM_NONE) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_comb begin
    command_next     = CMD_READ;
    page_addr_next   = '0;
    src_page_next    = '0;
    erase_block_next = '0;
    slot_out_next    = '0;
    unmapped_next    = 1'b0;
    last_next        = 1'b0;
    case (cmd.emit)
      EM_READ: begin
        command_next   = CMD_READ;
        page_addr_next = mapped ? {pbn, off} : '0;
        slot_out_next  = slot_q;
        unmapped_next  = !mapped;
        last_next      = 1'b1;
      end
      EM_PROG_FIRST: begin
        command_next   = CMD_PROG;
        page_addr_next = {PBN_W'(lbn), off};
        slot_out_next  = slot_q;
        last_next      = (off == '0);
      end
      EM_PROG_INPLACE: begin
        command_next   = CMD_PROG;
        page_addr_next = {pbn, off};
        slot_out_next  = slot_q;
        last_next      = 1'b1;
      end
      EM_MARK: begin
        command_next   = CMD_MARK;
        page_addr_next = {PBN_W'(lbn), OFF_W'(0)};
        last_next      = 1'b1;
      end
      EM_COPY: begin
        command_next   = CMD_COPY;
        page_addr_next = {free_blk, cnt};
        src_page_next  = {pbn, cnt};
      end
      EM_PROG_NEW: begin
        command_next   = CMD_PROG;
        page_addr_next = {free_blk, off};
        slot_out_next  = slot_q;
      end
      EM_ERASE: begin
        command_next     = CMD_ERASE;
        erase_block_next = pbn;
        last_next        = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.emit != EM_NONE) begin
      command     <= command_next;
      page_addr   <= page_addr_next;
      src_page    <= src_page_next;
      erase_block <= erase_block_next;
      slot_out    <= slot_out_next;
      unmapped    <= unmapped_next;
      last        <= last_next;
    end
  end

endmodule

`default_nettype wire

### sv/bmftl_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module bmftl_checker
  import bmftl_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_ready,
  input logic [CMD_W-1:0]  command,
  input logic [ADDR_W-1:0] page_addr,
  input logic [ADDR_W-1:0] src_page,
  input logic [PBN_W-1:0]  erase_block,
  input logic [SLOT_W-1:0] slot_out,
  input logic              unmapped,
  input logic              last
);

  // stalled command holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(command) && $stable(page_addr)
      && $stable(src_page) && $stable(last))
    else $error("stalled command changed");

  // erase carries only the block number
  a_erase: assert property (@(posedge clk) disable iff (rst)
    out_valid && command == CMD_ERASE |->
      page_addr == '0 && src_page == '0 && slot_out == '0 && last)
    else $error("bad erase fields");

  // unmapped flag only on a final read at page zero
  a_unmapped: assert property (@(posedge clk) disable iff (rst)
    out_valid && unmapped |-> command == CMD_READ && last && page_addr == '0)
    else $error("bad unmapped result");

  // copy keeps the page offset and never ends a request
  a_copy: assert property (@(posedge clk) disable iff (rst)
    out_valid && command == CMD_COPY |->
      !last && page_addr[OFF_W-1:0] == src_page[OFF_W-1:0] && erase_block == '0)
    else $error("bad copy fields");

endmodule

bind block_mapped_ftl bmftl_checker u_bmftl_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .command     (command),
  .page_addr   (page_addr),
  .src_page    (src_page),
  .erase_block (erase_block),
  .slot_out    (slot_out),
  .unmapped    (unmapped),
  .last        (last)
);

`default_nettype wire
